FILE: sv/xxh_pkg.sv
// Shared types, constants and helpers for the XXH64 stream hash.
package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	localparam int STRIPE_BYTES = 32;
	localparam int LANES = STRIPE_BYTES / 8;
	localparam int LANE_IDX_W = $clog2(LANES);

	localparam logic [3:0] FULL_LANE_BYTES = 4'd8;

	// One queued beat from the front end: count already normalized, data masked.
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RND_A,
		ST_RND_B,
		ST_FIN,
		ST_MRG_A,
		ST_MRG_B,
		ST_MRG_C,
		ST_TAIL,
		ST_TAIL_A,
		ST_TAIL_B,
		ST_TAIL_C,
		ST_WORD_A,
		ST_WORD_B,
		ST_BYTE_A,
		ST_BYTE_B,
		ST_AVL_A,
		ST_AVL_B,
		ST_OUT
	} state_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
		rotl = (x << n) | (x >> (64 - n));
	endfunction

endpackage

FILE: sv/xxh_front.sv
// Input front end: normalizes each beat and queues it for the hash engine.
module xxh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [63:0]         lane_data,
	input  logic [3:0]          byte_count,
	input  logic                last,
	output logic                item_valid,
	output xxh_pkg::item_t      item,
	input  logic                item_pop
);
	import xxh_pkg::*;

	item_t       fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	item_t       norm;
	logic        do_push;
	logic        do_pop;

	// Non-last beats and counts above eight are full lanes; mask unused bytes.
	always_comb begin
		norm.last = last;
		norm.cnt  = (!last || byte_count > FULL_LANE_BYTES) ? FULL_LANE_BYTES : byte_count;
		for (int b = 0; b < 8; b++) begin
			norm.data[8*b +: 8] = (4'(b) < norm.cnt) ? lane_data[8*b +: 8] : 8'h00;
		end
	end

	assign full       = (fill_q == 2'd2);
	assign item_valid = (fill_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wr_ptr_q] <= norm;
	end

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n) fill_q != 2'd3)
		else $error("queue fill out of range");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> fill_q == $past(fill_q) + 2'd1)
		else $error("queue fill did not grow on push");
	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 || fill_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill");
endmodule

FILE: sv/xxh_mul.sv
// 64x64 multiplier, low 64 bits, from three 32x32 partial products.
module xxh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] res,
	output logic        done,
	output logic        busy
);
	import xxh_pkg::*;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] res_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] prod;

	always_comb begin
		case (step_q)
			2'd0:    begin op_x = a_q[31:0];  op_y = b_q[31:0];  end
			2'd1:    begin op_x = a_q[31:0];  op_y = b_q[63:32]; end
			default: begin op_x = a_q[63:32]; op_y = b_q[31:0];  end
		endcase
		prod = {32'h0, op_x} * {32'h0, op_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == 2'd0) res_q <= prod;
			else res_q[63:32] <= res_q[63:32] + prod[31:0];
		end
	end

	assign res  = res_q;
	assign done = done_q;
	assign busy = busy_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("multiply done without a job");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("multiply busy and done together");
	a_three_steps: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy ##1 busy ##1 busy ##1 done)
		else $error("multiply step count broken");
endmodule

FILE: sv/xxh_back.sv
// Hash engine: lane rounds, merge, tail mixing and avalanche on one shared multiplier.
module xxh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [63:0]         seed,
	input  logic                item_valid,
	input  xxh_pkg::item_t      item,
	output logic                item_pop,
	output logic                empty,
	input  logic                pop,
	output logic [63:0]         digest
);
	import xxh_pkg::*;

	state_t                 state_q;
	state_t                 state_nx;
	logic [63:0]            acc_q  [LANES];
	logic [63:0]            pend_q [LANES];
	logic [63:0]            len_q;
	logic [63:0]            mseed_q;
	logic [LANE_IDX_W-1:0]  pos_q;
	logic [LANE_IDX_W-1:0]  idx_q;
	logic                   seen_q;
	logic                   in_msg_q;
	logic                   fin_q;
	logic [63:0]            h_q;
	logic [63:0]            t_q;
	logic [63:0]            part_q;
	logic [3:0]             pb_q;
	logic                   issued_q;
	logic                   out_valid_q;
	logic [63:0]            digest_q;

	logic                   mul_start;
	logic [63:0]            mul_a;
	logic [63:0]            mul_b;
	logic [63:0]            mul_res;
	logic                   mul_done;
	logic                   mul_busy;
	logic                   is_mul_st;
	logic                   out_push;
	logic [LANE_IDX_W-1:0]  eff_pos;
	logic [63:0]            eff_len;
	logic                   full_lane;
	logic [63:0]            merge_h;
	logic [63:0]            hx;

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.done   (mul_done),
		.busy   (mul_busy)
	);

	assign eff_pos   = in_msg_q ? pos_q : '0;
	assign eff_len   = (in_msg_q ? len_q : 64'h0) + {60'h0, item.cnt};
	assign full_lane = (item.cnt == FULL_LANE_BYTES);
	assign merge_h   = rotl(acc_q[0], 1) + rotl(acc_q[1], 7)
	                 + rotl(acc_q[2], 12) + rotl(acc_q[3], 18);
	assign hx        = h_q ^ t_q;

	always_comb begin
		case (state_q)
			ST_RND_A, ST_RND_B, ST_MRG_A, ST_MRG_B, ST_MRG_C,
			ST_TAIL_A, ST_TAIL_B, ST_TAIL_C, ST_WORD_A, ST_WORD_B,
			ST_BYTE_A, ST_BYTE_B, ST_AVL_A, ST_AVL_B: is_mul_st = 1'b1;
			default:                                  is_mul_st = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (full_lane && eff_pos == LANE_IDX_W'(LANES - 1)) state_nx = ST_RND_A;
					else if (item.last) state_nx = ST_FIN;
				end
			end
			ST_RND_A:  if (mul_done) state_nx = ST_RND_B;
			ST_RND_B: begin
				if (mul_done) begin
					if (idx_q != LANE_IDX_W'(LANES - 1)) state_nx = ST_RND_A;
					else if (fin_q) state_nx = ST_FIN;
					else state_nx = ST_IDLE;
				end
			end
			ST_FIN:    state_nx = seen_q ? ST_MRG_A : ST_TAIL;
			ST_MRG_A:  if (mul_done) state_nx = ST_MRG_B;
			ST_MRG_B:  if (mul_done) state_nx = ST_MRG_C;
			ST_MRG_C: begin
				if (mul_done)
					state_nx = (idx_q == LANE_IDX_W'(LANES - 1)) ? ST_TAIL : ST_MRG_A;
			end
			ST_TAIL: begin
				if (idx_q < pos_q) state_nx = ST_TAIL_A;
				else if (pb_q >= 4'd4) state_nx = ST_WORD_A;
				else if (pb_q != 4'd0) state_nx = ST_BYTE_A;
				else state_nx = ST_AVL_A;
			end
			ST_TAIL_A: if (mul_done) state_nx = ST_TAIL_B;
			ST_TAIL_B: if (mul_done) state_nx = ST_TAIL_C;
			ST_TAIL_C: if (mul_done) state_nx = ST_TAIL;
			ST_WORD_A: if (mul_done) state_nx = ST_WORD_B;
			ST_WORD_B: if (mul_done) state_nx = ST_TAIL;
			ST_BYTE_A: if (mul_done) state_nx = ST_BYTE_B;
			ST_BYTE_B: if (mul_done) state_nx = ST_TAIL;
			ST_AVL_A:  if (mul_done) state_nx = ST_AVL_B;
			ST_AVL_B:  if (mul_done) state_nx = ST_OUT;
			ST_OUT:    if (!out_valid_q) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// outputs: multiplier operands and handshakes
	always_comb begin
		mul_a     = 64'h0;
		mul_b     = 64'h0;
		item_pop  = 1'b0;
		out_push  = 1'b0;
		mul_start = is_mul_st && !issued_q;
		case (state_q)
			ST_IDLE:   item_pop = item_valid;
			ST_RND_A:  begin mul_a = pend_q[idx_q];                      mul_b = P2; end
			ST_RND_B:  begin mul_a = rotl(acc_q[idx_q] + t_q, 31);       mul_b = P1; end
			ST_MRG_A:  begin mul_a = acc_q[idx_q];                       mul_b = P2; end
			ST_MRG_B:  begin mul_a = rotl(t_q, 31);                      mul_b = P1; end
			ST_MRG_C:  begin mul_a = hx;                                 mul_b = P1; end
			ST_TAIL_A: begin mul_a = pend_q[idx_q];                      mul_b = P2; end
			ST_TAIL_B: begin mul_a = rotl(t_q, 31);                      mul_b = P1; end
			ST_TAIL_C: begin mul_a = rotl(hx, 27);                       mul_b = P1; end
			ST_WORD_A: begin mul_a = {32'h0, part_q[31:0]};              mul_b = P1; end
			ST_WORD_B: begin mul_a = rotl(hx, 23);                       mul_b = P2; end
			ST_BYTE_A: begin mul_a = {56'h0, part_q[7:0]};               mul_b = P5; end
			ST_BYTE_B: begin mul_a = rotl(hx, 11);                       mul_b = P1; end
			ST_AVL_A:  begin mul_a = h_q ^ (h_q >> 33);                  mul_b = P2; end
			ST_AVL_B:  begin mul_a = h_q ^ (h_q >> 29);                  mul_b = P3; end
			ST_OUT:    out_push = !out_valid_q;
			default:   mul_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			in_msg_q    <= 1'b0;
			seen_q      <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
			fin_q       <= 1'b0;
			len_q       <= 64'h0;
			mseed_q     <= 64'h0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (mul_start) issued_q <= 1'b1;
			else if (mul_done) issued_q <= 1'b0;
			if (out_push) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (!in_msg_q) begin
							mseed_q <= seed;
							seen_q  <= 1'b0;
						end
						in_msg_q <= !item.last;
						len_q    <= eff_len;
						fin_q    <= item.last;
						idx_q    <= '0;
						pos_q    <= full_lane ? eff_pos + 1'b1 : eff_pos;
					end
				end
				ST_RND_B: begin
					if (mul_done) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LANE_IDX_W'(LANES - 1)) seen_q <= 1'b1;
					end
				end
				ST_MRG_C:  if (mul_done) idx_q <= idx_q + 1'b1;
				ST_TAIL_C: if (mul_done) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_done) t_q <= mul_res;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (!in_msg_q) begin
						acc_q[0] <= seed + P1 + P2;
						acc_q[1] <= seed + P2;
						acc_q[2] <= seed;
						acc_q[3] <= seed - P1;
					end
					if (full_lane) begin
						pend_q[eff_pos] <= item.data;
						part_q <= 64'h0;
						pb_q   <= 4'd0;
					end else begin
						part_q <= item.data;
						pb_q   <= item.cnt;
					end
				end
			end
			ST_RND_B:  if (mul_done) acc_q[idx_q] <= mul_res;
			ST_FIN: begin
				if (seen_q) h_q <= merge_h;
				else h_q <= mseed_q + P5 + len_q;
			end
			ST_MRG_C: begin
				if (mul_done)
					h_q <= mul_res + P4
					     + ((idx_q == LANE_IDX_W'(LANES - 1)) ? len_q : 64'h0);
			end
			ST_TAIL_C: if (mul_done) h_q <= mul_res + P4;
			ST_WORD_B: begin
				if (mul_done) begin
					h_q    <= mul_res + P3;
					part_q <= part_q >> 32;
					pb_q   <= pb_q - 4'd4;
				end
			end
			ST_BYTE_B: begin
				if (mul_done) begin
					h_q    <= mul_res;
					part_q <= part_q >> 8;
					pb_q   <= pb_q - 4'd1;
				end
			end
			ST_AVL_A: if (mul_done) h_q <= mul_res;
			ST_AVL_B: if (mul_done) h_q <= mul_res;
			ST_OUT:   if (out_push) digest_q <= h_q ^ (h_q >> 32);
			default: ;
		endcase
	end

	assign empty  = !out_valid_q;
	assign digest = digest_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_valid_q)
		else $error("digest overwritten before read");
	a_start_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiply issued while busy");
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid && state_q == ST_IDLE)
		else $error("pop of empty front queue");
	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> issued_q && is_mul_st)
		else $error("multiply result with no waiting step");
endmodule

FILE: sv/xxh64_stream_hash_core.sv
// Top level of the streaming XXH64 hash core: front queue, hash engine, digest register.
// A non-final lane that leaves its stripe open is taken by the engine without a multiply; one that
//   completes a 32-byte stripe runs eight products on the shared 3-step multiplier.
// A last beat reaches the digest after its finalization steps, from the empty message (avalanche only)
//   to the longest path (merge, three tail lanes, 4+3 tail bytes).
// The two-deep input queue and the one-beat digest register let both sides stall on their own.
// Reset (arst_n low, asynchronous) empties both queues, clears the seed and the message state.
module xxh64_stream_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        push,
	output logic        full,
	input  logic [63:0] lane_data,
	input  logic [3:0]  byte_count,
	input  logic        last,
	// digest beats
	output logic        empty,
	input  logic        pop,
	output logic [63:0] digest,
	// seed register
	input  logic        seed_we,
	input  logic [63:0] seed_wdata
);
	import xxh_pkg::*;

	logic        item_valid;
	item_t       item;
	logic        item_pop;
	logic [63:0] seed_q;

	// Seed is sampled by the engine at the first beat of each message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= 64'h0;
		else if (seed_we) seed_q <= seed_wdata;
	end

	// Front end: count normalization, byte masking, two-entry queue.
	xxh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.lane_data  (lane_data),
		.byte_count (byte_count),
		.last       (last),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// Back end: stripe rounds and finalization, digest holding register.
	xxh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.digest     (digest)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !item_pop) |=> full)
		else $error("queue drained without a pop");
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty && $stable(digest))
		else $error("waiting digest lost");
	a_seed_write: assert property (@(posedge clk) disable iff (!arst_n)
		seed_we |=> seed_q == $past(seed_wdata))
		else $error("seed write lost");
endmodule
